/* sv/ezr_pkg.sv */
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared widths, CORDIC constants and helpers for the ZYX frame rotation.
// ----------------------------------------------------------------------------
package ezr_pkg;

	localparam int DATA_BITS    = 32;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 34;   // CORDIC datapath width, Q2.30 plus guard
	localparam int ZW           = 33;   // angle accumulator width
	localparam int QW           = 16;   // Q1.15 sine / cosine
	localparam int EW           = 18;   // matrix entry, Q1.15 with headroom past +/-1.0
	localparam int PW           = DATA_BITS + EW;  // product width
	localparam int SW           = PW + 2;           // sum of three products

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	typedef logic signed [DATA_BITS-1:0]  data_t;
	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [QW-1:0]         q15_t;
	typedef logic signed [EW-1:0]         ent_t;
	typedef logic signed [CW-1:0]         cw_t;
	typedef logic signed [ZW-1:0]         zw_t;

	function automatic zw_t atan_step(input int i);
		logic [31:0] t;
		begin
			case (i)
				0:  t = 32'h20000000;
				1:  t = 32'h12E4051E;
				2:  t = 32'h09FB385B;
				3:  t = 32'h051111D4;
				4:  t = 32'h028B0D43;
				5:  t = 32'h0145D7E1;
				6:  t = 32'h00A2F61E;
				7:  t = 32'h00517C55;
				8:  t = 32'h0028BE53;
				9:  t = 32'h00145F2F;
				10: t = 32'h000A2F98;
				11: t = 32'h000517CC;
				12: t = 32'h00028BE6;
				13: t = 32'h000145F3;
				14: t = 32'h0000A2FA;
				15: t = 32'h0000517D;
				default: t = '0;
			endcase
			return zw_t'({1'b0, t});
		end
	endfunction

	// Q2.30 -> Q1.15, round half up, clamp
	function automatic q15_t q15_round(input cw_t v);
		logic signed [CW-1:0] r;
		begin
			r = (v + cw_t'(16384)) >>> 15;
			if (r > cw_t'(32767))       return q15_t'(32767);
			else if (r < -cw_t'(32768)) return q15_t'(-32768);
			else                         return r[QW-1:0];
		end
	endfunction

endpackage

/* sv/ezr_if.sv */
// ----------------------------------------------------------------------------
// ezr_in_if / ezr_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface ezr_in_if;
	logic valid;
	logic ready;
	ezr_pkg::data_t  vec_x;
	ezr_pkg::data_t  vec_y;
	ezr_pkg::data_t  vec_z;
	ezr_pkg::angle_t roll_angle;
	ezr_pkg::angle_t pitch_angle;
	ezr_pkg::angle_t yaw_angle;
	modport source(output valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
		input ready);
	modport sink(input valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
		output ready);
endinterface

interface ezr_out_if;
	logic valid;
	logic ready;
	ezr_pkg::data_t body_x;
	ezr_pkg::data_t body_y;
	ezr_pkg::data_t body_z;
	modport source(output valid, body_x, body_y, body_z, input ready);
	modport sink(input valid, body_x, body_y, body_z, output ready);
endinterface

/* sv/ezr_cordic.sv */
// ----------------------------------------------------------------------------
// ezr_cordic
// Pipelined sine/cosine: quadrant fold, 16 CORDIC iterations over 4 stages
// (four iterations each), then Q1.15 rounding. Enable-driven.
// ----------------------------------------------------------------------------
module ezr_cordic (
	input  logic            clk,
	input  logic            en,
	input  ezr_pkg::angle_t angle,
	output ezr_pkg::q15_t   sin_q,
	output ezr_pkg::q15_t   cos_q
);

	localparam int NST = 4;
	localparam int PER = ezr_pkg::CORDIC_STEPS / NST;

	ezr_pkg::cw_t x_s [NST+1];
	ezr_pkg::cw_t y_s [NST+1];
	ezr_pkg::zw_t z_s [NST+1];
	logic         flip_s [NST+1];

	logic [31:0] a_turn;
	logic [31:0] a_fold;
	logic        flip;

	always_comb begin
		a_turn = {angle, {(32-ezr_pkg::ANGLE_BITS){1'b0}}};
		flip   = (a_turn[31:30] == 2'b01) || (a_turn[31:30] == 2'b10);
		a_fold = flip ? (a_turn + 32'h80000000) : a_turn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= ezr_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= ezr_pkg::zw_t'(signed'(a_fold));
			flip_s[0] <= flip;
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_st
		ezr_pkg::cw_t xc [PER+1];
		ezr_pkg::cw_t yc [PER+1];
		ezr_pkg::zw_t zc [PER+1];
		always_comb begin
			xc[0] = x_s[g];
			yc[0] = y_s[g];
			zc[0] = z_s[g];
			for (int k = 0; k < PER; k++) begin
				if (!zc[k][ezr_pkg::ZW-1]) begin
					xc[k+1] = xc[k] - (yc[k] >>> (g*PER+k));
					yc[k+1] = yc[k] + (xc[k] >>> (g*PER+k));
					zc[k+1] = zc[k] - ezr_pkg::atan_step(g*PER+k);
				end else begin
					xc[k+1] = xc[k] + (yc[k] >>> (g*PER+k));
					yc[k+1] = yc[k] - (xc[k] >>> (g*PER+k));
					zc[k+1] = zc[k] + ezr_pkg::atan_step(g*PER+k);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1]    <= xc[PER];
				y_s[g+1]    <= yc[PER];
				z_s[g+1]    <= zc[PER];
				flip_s[g+1] <= flip_s[g];
			end
		end
	end

	assign cos_q = ezr_pkg::q15_round(flip_s[NST] ? -x_s[NST] : x_s[NST]);
	assign sin_q = ezr_pkg::q15_round(flip_s[NST] ? -y_s[NST] : y_s[NST]);

endmodule

/* sv/euler_zyx_frame_rotation_core.sv */
// ----------------------------------------------------------------------------
// euler_zyx_frame_rotation_core
// Rotates a ground-frame Q16.16 vector into the body frame by R^T, with
// R = Rz(yaw) Ry(pitch) Rx(roll).
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle when not stalled, with the
// pipe made of the CORDIC (5 stages: fold plus four groups of four iterations) and
// the matrix/dot-product multipliers (5 stages). A stall freezes the whole
// pipe; the output register takes a new word whenever it is empty or taken.
module euler_zyx_frame_rotation_core (
	input  logic clk,
	input  logic arst_n,
	ezr_in_if.sink    in_ch,
	ezr_out_if.source out_ch
);

	localparam int LAT = 10;
	localparam int CL  = 5;

	logic en;
	logic [LAT-1:0] vld_q;

	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// vector delay to line up with CORDIC outputs
	ezr_pkg::data_t vx_d [CL];
	ezr_pkg::data_t vy_d [CL];
	ezr_pkg::data_t vz_d [CL];
	always_ff @(posedge clk) begin
		if (en) begin
			vx_d[0] <= in_ch.vec_x;
			vy_d[0] <= in_ch.vec_y;
			vz_d[0] <= in_ch.vec_z;
			for (int i = 1; i < CL; i++) begin
				vx_d[i] <= vx_d[i-1];
				vy_d[i] <= vy_d[i-1];
				vz_d[i] <= vz_d[i-1];
			end
		end
	end

	ezr_pkg::q15_t sr, cr, sp, cp, sy, cy;
	ezr_cordic u_roll  (.clk, .en, .angle(in_ch.roll_angle),  .sin_q(sr), .cos_q(cr));
	ezr_cordic u_pitch (.clk, .en, .angle(in_ch.pitch_angle), .sin_q(sp), .cos_q(cp));
	ezr_cordic u_yaw   (.clk, .en, .angle(in_ch.yaw_angle),   .sin_q(sy), .cos_q(cy));

	// stage 6: pairwise products Q2.30
	logic signed [31:0] cycp_s6, sycp_s6, cpsr_s6, cpcr_s6, sycr_s6, sysr_s6, cycr_s6, cysr_s6;
	logic signed [31:0] cysp_s6, sysp_s6;
	ezr_pkg::q15_t sr_s6, cr_s6, sp_s6;
	ezr_pkg::data_t vx_s6, vy_s6, vz_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			cycp_s6 <= cy * cp; sycp_s6 <= sy * cp;
			cpsr_s6 <= cp * sr; cpcr_s6 <= cp * cr;
			sycr_s6 <= sy * cr; sysr_s6 <= sy * sr;
			cycr_s6 <= cy * cr; cysr_s6 <= cy * sr;
			cysp_s6 <= cy * sp; sysp_s6 <= sy * sp;
			sr_s6 <= sr; cr_s6 <= cr; sp_s6 <= sp;
			vx_s6 <= vx_d[CL-1]; vy_s6 <= vy_d[CL-1]; vz_s6 <= vz_d[CL-1];
		end
	end

	// stage 7: matrix entries, exact at scale 2^45, rounded to Q1.15
	// (an entry can reach +1.0 or a little past it, hence the wider type)
	typedef logic signed [48:0] e45_t;
	function automatic ezr_pkg::ent_t ent(input e45_t e);
		e45_t r;
		begin
			r = (e + e45_t'(64'sd1 <<< 29)) >>> 30;
			return r[ezr_pkg::EW-1:0];
		end
	endfunction

	ezr_pkg::ent_t r00_s7, r01_s7, r02_s7, r10_s7, r11_s7, r12_s7, r20_s7, r21_s7, r22_s7;
	ezr_pkg::data_t vx_s7, vy_s7, vz_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			r00_s7 <= ent(e45_t'(cycp_s6) <<< 15);
			r01_s7 <= ent(e45_t'(cysp_s6) * e45_t'(sr_s6) - (e45_t'(sycr_s6) <<< 15));
			r02_s7 <= ent(e45_t'(cysp_s6) * e45_t'(cr_s6) + (e45_t'(sysr_s6) <<< 15));
			r10_s7 <= ent(e45_t'(sycp_s6) <<< 15);
			r11_s7 <= ent(e45_t'(sysp_s6) * e45_t'(sr_s6) + (e45_t'(cycr_s6) <<< 15));
			r12_s7 <= ent(e45_t'(sysp_s6) * e45_t'(cr_s6) - (e45_t'(cysr_s6) <<< 15));
			r20_s7 <= ent(-(e45_t'(sp_s6) <<< 30));
			r21_s7 <= ent(e45_t'(cpsr_s6) <<< 15);
			r22_s7 <= ent(e45_t'(cpcr_s6) <<< 15);
			vx_s7 <= vx_s6; vy_s7 <= vy_s6; vz_s7 <= vz_s6;
		end
	end

	// stage 8: nine 18x32 products
	typedef logic signed [ezr_pkg::PW-1:0] p_t;
	typedef logic signed [ezr_pkg::SW-1:0] s_t;
	p_t p_s8 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			p_s8[0] <= r00_s7 * vx_s7; p_s8[1] <= r10_s7 * vy_s7; p_s8[2] <= r20_s7 * vz_s7;
			p_s8[3] <= r01_s7 * vx_s7; p_s8[4] <= r11_s7 * vy_s7; p_s8[5] <= r21_s7 * vz_s7;
			p_s8[6] <= r02_s7 * vx_s7; p_s8[7] <= r12_s7 * vy_s7; p_s8[8] <= r22_s7 * vz_s7;
		end
	end

	// stage 9: exact sums
	s_t sum_s9 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sum_s9[k] <= s_t'(p_s8[3*k]) + s_t'(p_s8[3*k+1]) + s_t'(p_s8[3*k+2]);
			end
		end
	end

	// stage 10: round half up and saturate
	function automatic ezr_pkg::data_t sat(input s_t s);
		s_t r;
		begin
			r = (s + s_t'(16384)) >>> 15;
			if (r > s_t'({1'b0, {(ezr_pkg::DATA_BITS-1){1'b1}}}))
				return {1'b0, {(ezr_pkg::DATA_BITS-1){1'b1}}};
			else if (r < -s_t'({1'b1, {(ezr_pkg::DATA_BITS-1){1'b0}}}))
				return {1'b1, {(ezr_pkg::DATA_BITS-1){1'b0}}};
			else
				return r[ezr_pkg::DATA_BITS-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.body_x <= sat(sum_s9[0]);
			out_ch.body_y <= sat(sum_s9[1]);
			out_ch.body_z <= sat(sum_s9[2]);
		end
	end

endmodule
